FILE: rtl/nois_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the quarter-wave sine table of the nearest obstacle unit.
// Depends on nothing; every other file refers to it by scoped names.
package nois_pkg;

	localparam int unsigned SCAN_POINTS = 360;
	localparam int unsigned RANGE_BITS  = 16;
	localparam int unsigned ANGLE_BITS  = 9;
	localparam int unsigned COMP_BITS   = 17;
	localparam int unsigned MAG_BITS    = 15;
	localparam int unsigned QUARTER_DEG = 90;
	localparam int unsigned IDX_BITS    = 7;
	localparam int unsigned SENTINEL_PAD = 128;
	localparam logic [63:0] PI_Q30      = 64'd3373259426;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_MAX_RANGE   = 2'd0,
		REG_FWD_HALF    = 2'd1,
		REG_REV_LOW     = 2'd2,
		REG_REV_HIGH    = 2'd3
	} cfg_reg_t;

	// Driving direction codes
	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_REV  = 2'd1,
		DIR_FWD  = 2'd2
	} dir_t;

	// Item kinds
	typedef enum logic {
		REQ_DIRECTION = 1'b0,
		REQ_SAMPLE    = 1'b1
	} req_t;

	// One closed scan, handed from the front to the back
	typedef struct packed {
		logic                    found;
		logic [ANGLE_BITS-1:0]   angle;
		logic [RANGE_BITS-1:0]   range;
	} scan_rec_t;

	// Angle folded onto the first quadrant
	typedef struct packed {
		logic [IDX_BITS-1:0] idx;
		logic                neg;
	} fold_t;

	typedef logic [QUARTER_DEG:0][MAG_BITS-1:0] sin_table_t;

	// Unsigned quotient by compare and subtract; evaluated at elaboration only
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] rem;
		q = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Q0.15 sine of 0..90 degrees from an odd series in Q30; evaluated at elaboration only
	function automatic logic [MAG_BITS-1:0] sin_quarter(input logic [63:0] deg);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] div;
		x = div_u64(deg * PI_Q30, 64'd180);
		term = x;
		sum = x;
		for (int n = 1; n <= 6; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			div = 64'((2 * n) * (2 * n + 1));
			term = div_u64(term, div);
			if (n[0] == 1'b1) begin
				sum = (sum > term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		sum = (sum + 64'd16384) >> 15;
		if (sum > 64'd32767) begin
			sum = 64'd32767;
		end
		return sum[MAG_BITS-1:0];
	endfunction

	function automatic sin_table_t build_sin_table();
		sin_table_t t;
		for (int d = 0; d <= int'(QUARTER_DEG); d++) begin
			t[d] = sin_quarter(64'(d));
		end
		return t;
	endfunction

	localparam sin_table_t SIN_TABLE = build_sin_table();

endpackage

FILE: rtl/nois_front.sv
`timescale 1ns / 1ps
// Front part: configuration registers, direction state, sector test and running minimum.
// Pushes one scan record per closed scan. Depends on nois_pkg.
module nois_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [nois_pkg::RANGE_BITS-1:0]   cfg_data,
	input  logic                              accept,
	input  logic                              req_type,
	input  logic signed [1:0]                 velocity_sign,
	input  logic [nois_pkg::ANGLE_BITS-1:0]   sample_angle,
	input  logic [nois_pkg::RANGE_BITS-1:0]   range_sample,
	input  logic                              last_sample,
	output logic                              push,
	output nois_pkg::scan_rec_t               push_rec
);

	logic [nois_pkg::RANGE_BITS-1:0] full_scale_q;
	logic [7:0]                      fwd_half_q;
	logic [nois_pkg::ANGLE_BITS-1:0] rev_low_q;
	logic [nois_pkg::ANGLE_BITS-1:0] rev_high_q;
	nois_pkg::dir_t                  dir_q;
	logic [nois_pkg::RANGE_BITS-1:0] best_range_q;
	logic [nois_pkg::ANGLE_BITS-1:0] best_angle_q;
	logic                            best_valid_q;

	logic [nois_pkg::RANGE_BITS:0]   sent_sum;
	logic [nois_pkg::RANGE_BITS-1:0] sentinel;
	logic [nois_pkg::RANGE_BITS-1:0] limit;
	logic [nois_pkg::ANGLE_BITS:0]   wrap_sum;
	logic                            in_scan;
	logic                            in_sector;
	logic                            is_sample;
	logic                            hit;
	nois_pkg::dir_t                  dir_next;

	// Sentinel saturates at the largest range value
	always_comb begin
		sent_sum = {1'b0, full_scale_q} + (nois_pkg::RANGE_BITS+1)'(nois_pkg::SENTINEL_PAD);
		sentinel = sent_sum[nois_pkg::RANGE_BITS] ? '1 : sent_sum[nois_pkg::RANGE_BITS-1:0];
		limit    = best_valid_q ? best_range_q : sentinel;
	end

	// Sector test against the direction held now
	always_comb begin
		wrap_sum = {1'b0, sample_angle} + (nois_pkg::ANGLE_BITS+1)'(fwd_half_q);
		in_scan  = ({1'b0, sample_angle} < (nois_pkg::ANGLE_BITS+1)'(nois_pkg::SCAN_POINTS));
		unique case (dir_q)
			nois_pkg::DIR_FWD: in_sector = in_scan &&
				(({1'b0, sample_angle} <= (nois_pkg::ANGLE_BITS+1)'(fwd_half_q)) ||
				 (wrap_sum >= (nois_pkg::ANGLE_BITS+1)'(nois_pkg::SCAN_POINTS)));
			nois_pkg::DIR_REV: in_sector = in_scan &&
				(sample_angle >= rev_low_q) && (sample_angle <= rev_high_q);
			default:           in_sector = in_scan;
		endcase
		is_sample = (req_type == nois_pkg::REQ_SAMPLE);
		hit       = is_sample && in_sector && (range_sample < limit);
	end

	// Decode the velocity sign; any negative pattern selects reverse
	always_comb begin
		if (velocity_sign == 2'sd1) begin
			dir_next = nois_pkg::DIR_FWD;
		end else if (velocity_sign == 2'sd0) begin
			dir_next = nois_pkg::DIR_STOP;
		end else begin
			dir_next = nois_pkg::DIR_REV;
		end
	end

	// Record for a closing sample
	always_comb begin
		push              = accept && is_sample && last_sample;
		push_rec.found    = best_valid_q || hit;
		push_rec.range    = hit ? range_sample : limit;
		if (hit) begin
			push_rec.angle = sample_angle;
		end else if (best_valid_q) begin
			push_rec.angle = best_angle_q;
		end else begin
			push_rec.angle = '0;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= nois_pkg::RANGE_BITS'(896);
			fwd_half_q   <= 8'd45;
			rev_low_q    <= nois_pkg::ANGLE_BITS'(135);
			rev_high_q   <= nois_pkg::ANGLE_BITS'(225);
		end else if (cfg_we) begin
			unique case (nois_pkg::cfg_reg_t'(cfg_index))
				nois_pkg::REG_MAX_RANGE: full_scale_q <= cfg_data;
				nois_pkg::REG_FWD_HALF:  fwd_half_q   <= cfg_data[7:0];
				nois_pkg::REG_REV_LOW:   rev_low_q    <= cfg_data[nois_pkg::ANGLE_BITS-1:0];
				nois_pkg::REG_REV_HIGH:  rev_high_q   <= cfg_data[nois_pkg::ANGLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Direction and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q        <= nois_pkg::DIR_STOP;
			best_valid_q <= 1'b0;
		end else if (accept) begin
			if (!is_sample) begin
				dir_q <= dir_next;
			end else if (last_sample) begin
				best_valid_q <= 1'b0;
			end else if (hit) begin
				best_valid_q <= 1'b1;
			end
		end
	end

	// Running minimum payload
	always_ff @(posedge clk) begin
		if (accept && hit) begin
			best_range_q <= range_sample;
			best_angle_q <= sample_angle;
		end
	end

endmodule

FILE: rtl/nois_fifo.sv
`timescale 1ns / 1ps
// Short show-ahead queue of scan records between the front and the back.
// Depends on nois_pkg.
module nois_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  nois_pkg::scan_rec_t  push_rec,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output nois_pkg::scan_rec_t  pop_rec
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_BITS = $clog2(DEPTH);

	nois_pkg::scan_rec_t  mem_q [DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q;
	logic [PTR_BITS-1:0]  rd_ptr_q;
	logic [PTR_BITS:0]    count_q;
	logic                 do_push;
	logic                 do_pop;

	always_comb begin
		full      = (count_q == (PTR_BITS+1)'(DEPTH));
		not_empty = (count_q != '0);
		do_push   = push && !full;
		do_pop    = pop && not_empty;
		pop_rec   = mem_q[rd_ptr_q];
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

FILE: rtl/nois_back.sv
`timescale 1ns / 1ps
// Back part: sine/cosine lookup, range products and rounding, output register.
// Three stages with per-stage stall. Depends on nois_pkg.
module nois_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  rec_avail,
	input  nois_pkg::scan_rec_t                   rec,
	output logic                                  pop,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  found,
	output logic [nois_pkg::ANGLE_BITS-1:0]       nearest_angle,
	output logic [nois_pkg::RANGE_BITS-1:0]       nearest_range,
	output logic signed [nois_pkg::COMP_BITS-1:0] forward_component,
	output logic signed [nois_pkg::COMP_BITS-1:0] turn_component
);

	localparam int unsigned PROD_BITS = nois_pkg::RANGE_BITS + nois_pkg::MAG_BITS;

	// Fold 0..359 degrees onto the first quadrant
	function automatic nois_pkg::fold_t fold(input logic [nois_pkg::ANGLE_BITS-1:0] a);
		nois_pkg::fold_t f;
		if (a <= nois_pkg::ANGLE_BITS'(90)) begin
			f.idx = a[nois_pkg::IDX_BITS-1:0];
			f.neg = 1'b0;
		end else if (a <= nois_pkg::ANGLE_BITS'(180)) begin
			f.idx = nois_pkg::IDX_BITS'(nois_pkg::ANGLE_BITS'(180) - a);
			f.neg = 1'b0;
		end else if (a <= nois_pkg::ANGLE_BITS'(270)) begin
			f.idx = nois_pkg::IDX_BITS'(a - nois_pkg::ANGLE_BITS'(180));
			f.neg = 1'b1;
		end else begin
			f.idx = nois_pkg::IDX_BITS'(nois_pkg::ANGLE_BITS'(360) - a);
			f.neg = 1'b1;
		end
		return f;
	endfunction

	// Round a Q15 product to nearest and apply the sign
	function automatic logic [nois_pkg::COMP_BITS-1:0] finish(
		input logic [PROD_BITS-1:0] p,
		input logic                 neg
	);
		logic [PROD_BITS:0]               r;
		logic [nois_pkg::COMP_BITS-1:0]   m;
		r = {1'b0, p} + (PROD_BITS+1)'(16384);
		m = r[PROD_BITS:nois_pkg::MAG_BITS];
		return neg ? (~m + 1'b1) : m;
	endfunction

	logic adv1, adv2, adv3;
	logic v1_s1, v2_s2, v3_s3;

	logic [nois_pkg::ANGLE_BITS:0]   cos_sum;
	logic [nois_pkg::ANGLE_BITS-1:0] cos_angle;
	nois_pkg::fold_t                 sfold;
	nois_pkg::fold_t                 cfold;

	logic                            found_s1;
	logic [nois_pkg::ANGLE_BITS-1:0] angle_s1;
	logic [nois_pkg::RANGE_BITS-1:0] range_s1;
	logic [nois_pkg::MAG_BITS-1:0]   cmag_s1;
	logic [nois_pkg::MAG_BITS-1:0]   smag_s1;
	logic                            cneg_s1;
	logic                            tneg_s1;

	logic                            found_s2;
	logic [nois_pkg::ANGLE_BITS-1:0] angle_s2;
	logic [nois_pkg::RANGE_BITS-1:0] range_s2;
	logic [PROD_BITS-1:0]            fprod_s2;
	logic [PROD_BITS-1:0]            tprod_s2;
	logic                            cneg_s2;
	logic                            tneg_s2;

	// Stage advance chain
	always_comb begin
		adv3 = !v3_s3 || !out_stall;
		adv2 = !v2_s2 || adv3;
		adv1 = !v1_s1 || adv2;
		pop  = rec_avail && adv1;
		out_valid = v3_s3;
	end

	// Quadrant folding for sine and cosine
	always_comb begin
		cos_sum   = {1'b0, rec.angle} + (nois_pkg::ANGLE_BITS+1)'(90);
		cos_angle = (cos_sum >= (nois_pkg::ANGLE_BITS+1)'(nois_pkg::SCAN_POINTS)) ?
			nois_pkg::ANGLE_BITS'(cos_sum - (nois_pkg::ANGLE_BITS+1)'(nois_pkg::SCAN_POINTS)) :
			cos_sum[nois_pkg::ANGLE_BITS-1:0];
		sfold = fold(rec.angle);
		cfold = fold(cos_angle);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v1_s1 <= pop;
			end
			if (adv2) begin
				v2_s2 <= v1_s1;
			end
			if (adv3) begin
				v3_s3 <= v2_s2;
			end
		end
	end

	// Stage 1: table lookup
	always_ff @(posedge clk) begin
		if (pop) begin
			found_s1 <= rec.found;
			angle_s1 <= rec.angle;
			range_s1 <= rec.range;
			smag_s1  <= nois_pkg::SIN_TABLE[sfold.idx];
			cmag_s1  <= nois_pkg::SIN_TABLE[cfold.idx];
			cneg_s1  <= cfold.neg;
			tneg_s1  <= !sfold.neg;
		end
	end

	// Stage 2: products
	always_ff @(posedge clk) begin
		if (adv2 && v1_s1) begin
			found_s2 <= found_s1;
			angle_s2 <= angle_s1;
			range_s2 <= range_s1;
			fprod_s2 <= PROD_BITS'(range_s1) * PROD_BITS'(cmag_s1);
			tprod_s2 <= PROD_BITS'(range_s1) * PROD_BITS'(smag_s1);
			cneg_s2  <= cneg_s1;
			tneg_s2  <= tneg_s1;
		end
	end

	// Stage 3: round, sign and hold the beat for the consumer
	always_ff @(posedge clk) begin
		if (adv3 && v2_s2) begin
			found         <= found_s2;
			nearest_angle <= angle_s2;
			nearest_range <= range_s2;
			forward_component <= found_s2 ? finish(fprod_s2, cneg_s2) : '0;
			turn_component    <= found_s2 ? finish(tprod_s2, tneg_s2) : '0;
		end
	end

endmodule

FILE: rtl/nearest_obstacle_in_sector_unit.sv
`timescale 1ns / 1ps
// Nearest obstacle in the driving-direction sector of a laser scan.
// Throughput: one item per cycle while in_stall is low; sector test and compare take each beat.
// Path: a closing sample's record is written to the queue on the accepting edge, then passes
// three registered back stages: table lookup, multiply, round.
// Reset: asynchronous; clears direction to stopped, the search and the queue; no clearing pass.
module nearest_obstacle_in_sector_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [1:0]                            cfg_index,
	input  logic [nois_pkg::RANGE_BITS-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  req_type,
	input  logic signed [1:0]                     velocity_sign,
	input  logic [nois_pkg::ANGLE_BITS-1:0]       sample_angle,
	input  logic [nois_pkg::RANGE_BITS-1:0]       range_sample,
	input  logic                                  last_sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  found,
	output logic [nois_pkg::ANGLE_BITS-1:0]       nearest_angle,
	output logic [nois_pkg::RANGE_BITS-1:0]       nearest_range,
	output logic signed [nois_pkg::COMP_BITS-1:0] forward_component,
	output logic signed [nois_pkg::COMP_BITS-1:0] turn_component
);

	logic                accept;
	logic                push;
	nois_pkg::scan_rec_t push_rec;
	logic                full;
	logic                pop;
	logic                not_empty;
	nois_pkg::scan_rec_t pop_rec;

	// Stall the input while the queue has no room
	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	nois_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.accept        (accept),
		.req_type      (req_type),
		.velocity_sign (velocity_sign),
		.sample_angle  (sample_angle),
		.range_sample  (range_sample),
		.last_sample   (last_sample),
		.push          (push),
		.push_rec      (push_rec)
	);

	nois_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_rec   (pop_rec)
	);

	nois_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.rec_avail         (not_empty),
		.rec               (pop_rec),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.found             (found),
		.nearest_angle     (nearest_angle),
		.nearest_range     (nearest_range),
		.forward_component (forward_component),
		.turn_component    (turn_component)
	);

endmodule

FILE: dv/nearest_obstacle_in_sector_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for nearest_obstacle_in_sector_unit: directed scans, then random sweeps.
// Depends on nois_pkg and the unit; holds its own sector search, sine series and scoreboard.
module nearest_obstacle_in_sector_unit_tb;

	// Velocity sign patterns as driven on the port
	localparam logic [1:0] VEL_STOP = 2'b00;
	localparam logic [1:0] VEL_FWD  = 2'b01;
	localparam logic [1:0] VEL_ODD  = 2'b10;
	localparam logic [1:0] VEL_REV  = 2'b11;

	typedef struct packed {
		nois_pkg::req_t                  kind;
		logic [1:0]                      vsign;
		logic [nois_pkg::ANGLE_BITS-1:0] angle;
		logic [nois_pkg::RANGE_BITS-1:0] rng;
		logic                            last;
	} beat_t;

	typedef struct packed {
		logic                                  found;
		logic [nois_pkg::ANGLE_BITS-1:0]       angle;
		logic [nois_pkg::RANGE_BITS-1:0]       reach;
		logic signed [nois_pkg::COMP_BITS-1:0] fwd;
		logic signed [nois_pkg::COMP_BITS-1:0] turn;
	} scan_verdict_t;

	// Sector search state, register copies and the queue of verdicts still to come
	class sector_scoreboard;
		logic [15:0]                     full_scale;
		logic [7:0]                      fwd_half;
		logic [8:0]                      rev_low;
		logic [8:0]                      rev_high;
		nois_pkg::dir_t                  heading;
		logic [nois_pkg::RANGE_BITS-1:0] best_rng;
		logic [nois_pkg::ANGLE_BITS-1:0] best_ang;
		bit                              best_ok;
		int unsigned                     quarter_sine [0:90];
		scan_verdict_t                   awaiting [$];
		int                              beats;
		int                              scans;
		int                              hits;
		int                              failures;

		function new();
			for (int d = 0; d <= 90; d++) begin
				quarter_sine[d] = series_sine(d);
			end
			full_scale = 16'd896;
			fwd_half = 8'd45;
			rev_low = 9'd135;
			rev_high = 9'd225;
			heading = nois_pkg::DIR_STOP;
			best_ok = 1'b0;
			best_ang = '0;
			best_rng = sentinel();
		endfunction

		// Q0.15 sine of 0..90 degrees: odd series evaluated in Q30, then rounded
		function int unsigned series_sine(int deg);
			longint unsigned x;
			longint unsigned term;
			longint unsigned sum;
			longint unsigned div;
			x = 64'(deg);
			x = x * 64'd3373259426 / 64'd180;
			term = x;
			sum = x;
			for (int n = 1; n <= 6; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				div = 64'((2 * n) * (2 * n + 1));
				term = term / div;
				if (n % 2 == 1) begin
					sum = (sum > term) ? sum - term : 64'd0;
				end else begin
					sum = sum + term;
				end
			end
			sum = (sum + 64'd16384) >> 15;
			return (sum > 64'd32767) ? 32767 : int'(sum);
		endfunction

		// Fold a whole degree onto the first quadrant; flag the lower half plane
		function int unsigned signed_sine(int a, output bit neg);
			neg = (a > 180);
			if (a <= 90) return quarter_sine[a];
			if (a <= 180) return quarter_sine[180 - a];
			if (a <= 270) return quarter_sine[a - 180];
			return quarter_sine[360 - a];
		endfunction

		// Round r * mag / 2^15 half up, then apply the sign
		function logic signed [nois_pkg::COMP_BITS-1:0] project(
				logic [nois_pkg::RANGE_BITS-1:0] r, int unsigned mag, bit neg);
			longint unsigned m;
			logic signed [nois_pkg::COMP_BITS-1:0] v;
			m = r;
			m = (m * mag + 64'd16384) >> 15;
			v = nois_pkg::COMP_BITS'(m);
			return neg ? -v : v;
		endfunction

		function logic [nois_pkg::RANGE_BITS-1:0] sentinel();
			int unsigned s;
			s = int'(full_scale) + nois_pkg::SENTINEL_PAD;
			return (s > 65535) ? 16'hFFFF : 16'(s);
		endfunction

		function bit covers(logic [nois_pkg::ANGLE_BITS-1:0] a);
			if (a >= nois_pkg::SCAN_POINTS) return 1'b0;
			case (heading)
				nois_pkg::DIR_FWD: return (a <= fwd_half) ||
					(int'(a) + int'(fwd_half) >= nois_pkg::SCAN_POINTS);
				nois_pkg::DIR_REV: return (a >= rev_low) && (a <= rev_high);
				default: return 1'b1;
			endcase
		endfunction

		function void set_reg(nois_pkg::cfg_reg_t idx, logic [15:0] v);
			case (idx)
				nois_pkg::REG_MAX_RANGE: full_scale = v;
				nois_pkg::REG_FWD_HALF:  fwd_half = v[7:0];
				nois_pkg::REG_REV_LOW:   rev_low = v[8:0];
				default:                 rev_high = v[8:0];
			endcase
		endfunction

		// Advance the search by one accepted beat; queue a verdict when a scan closes
		function void note_beat(beat_t b);
			scan_verdict_t v;
			logic [nois_pkg::RANGE_BITS-1:0] bar;
			bit sn;
			bit cn;
			int unsigned smag;
			int unsigned cmag;
			beats++;
			if (b.kind == nois_pkg::REQ_DIRECTION) begin
				if (b.vsign == VEL_FWD) heading = nois_pkg::DIR_FWD;
				else if (b.vsign == VEL_STOP) heading = nois_pkg::DIR_STOP;
				else heading = nois_pkg::DIR_REV;
				return;
			end
			bar = best_ok ? best_rng : sentinel();
			if (covers(b.angle) && b.rng < bar) begin
				best_rng = b.rng;
				best_ang = b.angle;
				best_ok = 1'b1;
			end
			if (!b.last) return;
			if (best_ok) begin
				smag = signed_sine(int'(best_ang), sn);
				cmag = signed_sine((int'(best_ang) + 90) % 360, cn);
				v.found = 1'b1;
				v.angle = best_ang;
				v.reach = best_rng;
				v.fwd = project(best_rng, cmag, cn);
				v.turn = project(best_rng, smag, !sn);
				hits++;
			end else begin
				v.found = 1'b0;
				v.angle = '0;
				v.reach = sentinel();
				v.fwd = '0;
				v.turn = '0;
			end
			awaiting.push_back(v);
			scans++;
			best_rng = sentinel();
			best_ang = '0;
			best_ok = 1'b0;
		endfunction

		function void check_result(scan_verdict_t got);
			scan_verdict_t want;
			if (awaiting.size() == 0) begin
				$error("result beat with no closed scan pending: found %0d angle %0d",
					got.found, got.angle);
				failures++;
				return;
			end
			want = awaiting.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				failures++;
			end
			if (got.angle !== want.angle) begin
				$error("nearest_angle: expected %0d, got %0d", want.angle, got.angle);
				failures++;
			end
			if (got.reach !== want.reach) begin
				$error("nearest_range: expected %0d, got %0d", want.reach, got.reach);
				failures++;
			end
			if (got.fwd !== want.fwd) begin
				$error("forward_component: expected %0d, got %0d",
					$signed(want.fwd), $signed(got.fwd));
				failures++;
			end
			if (got.turn !== want.turn) begin
				$error("turn_component: expected %0d, got %0d",
					$signed(want.turn), $signed(got.turn));
				failures++;
			end
		endfunction
	endclass

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  cfg_we = 1'b0;
	logic [1:0]                            cfg_index = nois_pkg::REG_MAX_RANGE;
	logic [nois_pkg::RANGE_BITS-1:0]       cfg_data = '0;
	logic                                  in_valid = 1'b0;
	logic                                  in_stall;
	logic                                  req_type = nois_pkg::REQ_DIRECTION;
	logic signed [1:0]                     velocity_sign = VEL_STOP;
	logic [nois_pkg::ANGLE_BITS-1:0]       sample_angle = '0;
	logic [nois_pkg::RANGE_BITS-1:0]       range_sample = '0;
	logic                                  last_sample = 1'b0;
	logic                                  out_valid;
	logic                                  out_stall = 1'b0;
	logic                                  found;
	logic [nois_pkg::ANGLE_BITS-1:0]       nearest_angle;
	logic [nois_pkg::RANGE_BITS-1:0]       nearest_range;
	logic signed [nois_pkg::COMP_BITS-1:0] forward_component;
	logic signed [nois_pkg::COMP_BITS-1:0] turn_component;

	sector_scoreboard board;
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;
	bit          taken = 1'b0;
	int          rx_hold = 0;
	int unsigned sweep_at = 0;
	int          settings = 0;

	nearest_obstacle_in_sector_unit dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.req_type          (req_type),
		.velocity_sign     (velocity_sign),
		.sample_angle      (sample_angle),
		.range_sample      (range_sample),
		.last_sample       (last_sample),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.found             (found),
		.nearest_angle     (nearest_angle),
		.nearest_range     (nearest_range),
		.forward_component (forward_component),
		.turn_component    (turn_component)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check result beats mid-cycle, where valid and stall are settled for the next edge
	always @(negedge clk) begin
		taken = 1'b0;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			board.check_result({found, nearest_angle, nearest_range,
				forward_component, turn_component});
			taken = 1'b1;
		end
	end

	// Hold the result side off for a random count after each taken beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_hold = 0;
		end else begin
			if (taken) rx_hold = rx_calm ? 0 : $urandom_range(0, 12);
			if (rx_hold > 0) begin
				out_stall <= 1'b1;
				rx_hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic beat_t dir_beat(logic [1:0] vs, logic last);
		beat_t b;
		b.kind = nois_pkg::REQ_DIRECTION;
		b.vsign = vs;
		b.angle = 9'($urandom_range(0, 511));
		b.rng = 16'($urandom);
		b.last = last;
		return b;
	endfunction

	function automatic beat_t scan_beat(int unsigned ang, int unsigned rng, logic last);
		beat_t b;
		b.kind = nois_pkg::REQ_SAMPLE;
		b.vsign = 2'($urandom_range(0, 3));
		b.angle = 9'(ang);
		b.rng = 16'(rng);
		b.last = last;
		return b;
	endfunction

	// Mostly ascending sweeps with ranges around the held best and the sentinel
	function automatic beat_t random_beat();
		beat_t b;
		int unsigned roll;
		int unsigned ang;
		int unsigned bar;
		int near;
		roll = $urandom_range(0, 99);
		if (roll < 8) return dir_beat(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
		bar = board.best_ok ? board.best_rng : board.sentinel();
		case ($urandom_range(0, 5))
			0: b.rng = 16'($urandom);
			1: begin
				near = int'(board.sentinel()) + int'($urandom_range(0, 2)) - 1;
				b.rng = (near > 65535) ? 16'hFFFF : 16'(near);
			end
			2: b.rng = 16'(bar);
			default: b.rng = 16'($urandom_range(0, board.sentinel()));
		endcase
		b.kind = nois_pkg::REQ_SAMPLE;
		b.vsign = 2'($urandom_range(0, 3));
		if (roll < 12) begin
			// out-of-scan or out-of-order sample
			ang = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 359)
				: $urandom_range(nois_pkg::SCAN_POINTS, 511);
			b.last = ($urandom_range(0, 5) == 0);
		end else begin
			ang = sweep_at + $urandom_range(0, 25);
			b.last = ($urandom_range(0, 9) == 0);
			if (ang >= nois_pkg::SCAN_POINTS - 1) begin
				ang = nois_pkg::SCAN_POINTS - 1;
				b.last = 1'b1;
			end
			sweep_at = ang + 1;
		end
		if (b.last) sweep_at = $urandom_range(0, 10);
		b.angle = 9'(ang);
		return b;
	endfunction

	task automatic send_beat(beat_t b);
		int gap;
		bit stalled;
		gap = tx_calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= b.kind;
		velocity_sign <= b.vsign;
		sample_angle <= b.angle;
		range_sample <= b.rng;
		last_sample <= b.last;
		do begin
			@(negedge clk);
			stalled = (in_stall !== 1'b0);
			@(posedge clk);
		end while (stalled);
		board.note_beat(b);
	endtask

	// Drop valid, wait for every pending verdict, then let the back stages settle
	task automatic drain();
		in_valid <= 1'b0;
		while (board.awaiting.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(nois_pkg::cfg_reg_t idx, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		board.set_reg(idx, v);
	endtask

	task automatic load_sector_regs(int unsigned mr, int unsigned fh, int unsigned lo,
			int unsigned hi);
		write_reg(nois_pkg::REG_MAX_RANGE, 16'(mr));
		write_reg(nois_pkg::REG_FWD_HALF, 16'(fh));
		write_reg(nois_pkg::REG_REV_LOW, 16'(lo));
		write_reg(nois_pkg::REG_REV_HIGH, 16'(hi));
		cfg_we <= 1'b0;
		settings++;
	endtask

	initial begin
		beat_t plan [$];
		int sent;
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed scans under the reset register values
		plan.push_back(scan_beat(0, 65535, 1'b0));
		plan.push_back(scan_beat(511, 0, 1'b1));
		plan.push_back(dir_beat(VEL_FWD, 1'b1));
		plan.push_back(scan_beat(30, 500, 1'b0));
		plan.push_back(scan_beat(40, 500, 1'b0));
		plan.push_back(scan_beat(100, 10, 1'b0));
		plan.push_back(scan_beat(315, 499, 1'b0));
		plan.push_back(scan_beat(359, 499, 1'b1));
		plan.push_back(dir_beat(VEL_REV, 1'b0));
		plan.push_back(scan_beat(134, 1, 1'b0));
		plan.push_back(scan_beat(135, 300, 1'b0));
		plan.push_back(dir_beat(VEL_FWD, 1'b0));
		plan.push_back(scan_beat(200, 100, 1'b0));
		plan.push_back(scan_beat(350, 200, 1'b1));
		plan.push_back(dir_beat(VEL_ODD, 1'b0));
		plan.push_back(scan_beat(225, 0, 1'b0));
		plan.push_back(scan_beat(226, 0, 1'b1));
		plan.push_back(dir_beat(VEL_STOP, 1'b0));
		plan.push_back(scan_beat(45, 1023, 1'b0));
		plan.push_back(scan_beat(90, 1023, 1'b0));
		plan.push_back(scan_beat(270, 1000, 1'b0));
		plan.push_back(scan_beat(359, 1024, 1'b1));
		plan.push_back(dir_beat(VEL_FWD, 1'b0));
		plan.push_back(scan_beat(0, 700, 1'b0));
		plan.push_back(scan_beat(46, 1, 1'b1));
		foreach (plan[i]) send_beat(plan[i]);
		drain();

		// Random sweeps over several register settings; scans stay open across writes
		for (int phase = 1; phase <= 5; phase++) begin
			case (phase)
				1: load_sector_regs(65407, 179, 0, 359);
				2: load_sector_regs(0, 0, 359, 0);
				5: load_sector_regs(1000, 90, 90, 270);
				default: load_sector_regs($urandom_range(0, 65407), $urandom_range(0, 179),
					$urandom_range(0, 359), $urandom_range(0, 359));
			endcase
			sent = 0;
			while (sent < 75) begin
				if (sent % 25 == 0) begin
					tx_calm = ($urandom_range(0, 3) == 0);
					rx_calm = ($urandom_range(0, 3) == 0);
				end
				send_beat(random_beat());
				sent++;
			end
			drain();
		end

		$display("Run covered %0d input beats and %0d closed scans (%0d with a hit)",
			board.beats, board.scans, board.hits);
		$display("across %0d register settings plus the reset values.", settings);
		if (board.failures == 0 && board.awaiting.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
